// ----- rtl/core/ssip_pkg.sv -----
// ----------------------------------------------------------------------------
// Speed schedule incremental PID package
// Shared field widths, constants, register codes and beat payload types.
// ----------------------------------------------------------------------------
package ssip_pkg;

   localparam int SPEED_W      = 9;
   localparam int GAIN_W       = 12;
   localparam int RATIO_W      = 9;
   localparam int COUNT_W      = 16;
   localparam int MEAS_W       = 15;
   localparam int DUTY_W       = 13;
   localparam int COL_W        = 8;
   localparam int OFFSET_W     = 5;
   localparam int ERR_W        = 17;
   localparam int TERM_W       = 16;
   localparam int ACCUM_W      = 14;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 3 * SPEED_W;

   localparam int CENTER_REF   = 40;
   localparam int OFFSET_CAP   = 20;
   localparam int DRIVE_LIMIT  = 8000;

   // floor(n / 20) == (n * 3277) >> 16 for n below 2**14
   localparam int DIV20_RECIP   = 3277;
   localparam int DIV20_RECIP_W = 12;
   localparam int DIV20_SHIFT   = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P         = 4'd0,
      CSR_GAIN_I         = 4'd1,
      CSR_GAIN_D         = 4'd2,
      CSR_SPEED_LOW      = 4'd3,
      CSR_SPEED_HIGH     = 4'd4,
      CSR_RING_SPEEDS    = 4'd5,
      CSR_OBSTACLE_SPEED = 4'd6,
      CSR_SLOW_SPEED     = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] encoder_count;
      logic [COL_W-1:0]          center_col;
      logic [RATIO_W-1:0]        straight_ratio;
      logic [RATIO_W-1:0]        lateral_ratio;
      logic                      ring_found;
      logic                      ring_entering;
      logic                      ring_exiting;
      logic                      obstacle;
      logic                      full_speed_mode;
   } req_item_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty_forward;
      logic [DUTY_W-1:0]  duty_reverse;
      logic [SPEED_W-1:0] goal_speed;
      logic [MEAS_W-1:0]  measured_speed;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   typedef struct packed {
      logic [GAIN_W-1:0]    gain_p;
      logic [GAIN_W-1:0]    gain_i;
      logic [GAIN_W-1:0]    gain_d;
      logic [SPEED_W-1:0]   speed_low;
      logic [SPEED_W-1:0]   speed_high;
      logic [3*SPEED_W-1:0] ring_speeds;
      logic [SPEED_W-1:0]   obstacle_speed;
      logic [SPEED_W-1:0]   slow_speed;
   } cfg_type;

   typedef struct packed {
      logic [SPEED_W-1:0] goal;
      logic [MEAS_W-1:0]  meas;
   } goal_item_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:         12'd800,
      gain_i:         12'd160,
      gain_d:         12'd0,
      speed_low:      9'd160,
      speed_high:     9'd280,
      ring_speeds:    27'd39406245,
      obstacle_speed: 9'd190,
      slow_speed:     9'd130
   };

endpackage

// ----- rtl/core/ssip_chan_if.sv -----
// ----------------------------------------------------------------------------
// Speed schedule incremental PID channel
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ssip_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      output valid,
      output payload,
      input  ready
   );

   modport sink (
      input  valid,
      input  payload,
      output ready
   );

endinterface

// ----- rtl/core/ssip_goal.sv -----
// ----------------------------------------------------------------------------
// Speed schedule incremental PID goal stages
// Two-stage target speed schedule: offset ramp, curve limits, event overrides.
// ----------------------------------------------------------------------------
module ssip_goal
   import ssip_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_item_type  in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output goal_item_type out_item
);

   localparam int LIM_W  = SPEED_W + RATIO_W - RATIO_FRAC_BITS;
   localparam int CAP_W  = ((LIM_W > SPEED_W) ? LIM_W : SPEED_W) + 1;
   localparam int NUM_W  = $clog2(OFFSET_CAP * (2 ** SPEED_W));
   localparam int PROD_W = SPEED_W + OFFSET_W + 2;
   localparam int QUOT_W = NUM_W + DIV20_RECIP_W;

   typedef struct packed {
      logic ring_found;
      logic ring_entering;
      logic ring_exiting;
      logic obstacle;
      logic full_speed_mode;
   } event_type;

   logic en_a, en_b;

   logic                    a_valid_ff, a_valid_in;
   logic [NUM_W-1:0]        a_num_ff, a_num_in;
   logic [LIM_W-1:0]        a_lim_ff, a_lim_in;
   logic                    a_skip_ff, a_skip_in;
   logic [MEAS_W-1:0]       a_meas_ff, a_meas_in;
   event_type               a_event_ff, a_event_in;

   logic                    b_valid_ff, b_valid_in;
   goal_item_type           b_item_ff, b_item_in;

   logic signed [COL_W:0]   col_diff;
   logic [COL_W-1:0]        col_abs;
   logic [OFFSET_W-1:0]     offset;
   logic signed [SPEED_W:0] span;
   logic signed [PROD_W-1:0] span_off;
   logic [NUM_W-1:0]        high_x20;
   logic signed [PROD_W-1:0] num_full;
   logic [SPEED_W+RATIO_W-1:0] lim_s_full, lim_l_full;
   logic [LIM_W-1:0]        lim_s, lim_l;

   logic [QUOT_W-1:0]       quot_full;
   logic [SPEED_W-1:0]      goal_lin;
   logic [CAP_W-1:0]        cap;
   logic [SPEED_W-1:0]      goal;

   assign en_b     = !b_valid_ff || out_ready;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   // stage A: offset ramp numerator and curve limits
   always_comb begin
      col_diff   = $signed({1'b0, in_item.center_col}) - $signed((COL_W+1)'(CENTER_REF));
      col_abs    = col_diff[COL_W] ? COL_W'(-col_diff) : col_diff[COL_W-1:0];
      offset     = (col_abs > COL_W'(OFFSET_CAP)) ? OFFSET_W'(OFFSET_CAP)
                                                 : col_abs[OFFSET_W-1:0];
      span       = $signed({1'b0, cfg.speed_high}) - $signed({1'b0, cfg.speed_low});
      span_off   = span * $signed({1'b0, offset});
      high_x20   = NUM_W'(cfg.speed_high) * NUM_W'(OFFSET_CAP);
      num_full   = $signed({2'b00, high_x20}) - span_off;
      lim_s_full = span[SPEED_W-1:0] * in_item.straight_ratio;
      lim_l_full = span[SPEED_W-1:0] * in_item.lateral_ratio;
      lim_s      = lim_s_full[SPEED_W+RATIO_W-1:RATIO_FRAC_BITS];
      lim_l      = lim_l_full[SPEED_W+RATIO_W-1:RATIO_FRAC_BITS];

      a_valid_in = en_a ? in_valid : a_valid_ff;
      a_num_in   = num_full[NUM_W-1:0];
      a_lim_in   = (lim_s < lim_l) ? lim_s : lim_l;
      a_skip_in  = span[SPEED_W];
      a_meas_in  = in_item.encoder_count[COUNT_W-1] ? '0
                                                    : in_item.encoder_count[MEAS_W-1:0];
      a_event_in = '{
         ring_found:      in_item.ring_found,
         ring_entering:   in_item.ring_entering,
         ring_exiting:    in_item.ring_exiting,
         obstacle:        in_item.obstacle,
         full_speed_mode: in_item.full_speed_mode
      };
   end

   // stage B: divide by the offset cap, limit, override
   always_comb begin
      quot_full = QUOT_W'(a_num_ff) * QUOT_W'(DIV20_RECIP);
      goal_lin  = quot_full[DIV20_SHIFT +: SPEED_W];
      cap       = CAP_W'(cfg.speed_low) + CAP_W'(a_lim_ff);
      goal      = goal_lin;
      if (!a_skip_ff && (CAP_W'(goal_lin) > cap)) begin
         goal = cap[SPEED_W-1:0];
      end
      if (a_event_ff.ring_found) begin
         goal = cfg.ring_speeds[0 +: SPEED_W];
      end
      if (a_event_ff.ring_entering) begin
         goal = cfg.ring_speeds[SPEED_W +: SPEED_W];
      end
      if (a_event_ff.ring_exiting) begin
         goal = cfg.ring_speeds[2*SPEED_W +: SPEED_W];
      end
      if (a_event_ff.obstacle) begin
         goal = cfg.obstacle_speed;
      end
      if (!a_event_ff.full_speed_mode) begin
         goal = cfg.slow_speed;
      end

      b_valid_in = en_b ? a_valid_ff : b_valid_ff;
      b_item_in  = '{goal: goal, meas: a_meas_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_num_ff   <= a_num_in;
         a_lim_ff   <= a_lim_in;
         a_skip_ff  <= a_skip_in;
         a_meas_ff  <= a_meas_in;
         a_event_ff <= a_event_in;
      end
      if (en_b) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ----- rtl/core/ssip_pid.sv -----
// ----------------------------------------------------------------------------
// Speed schedule incremental PID controller stages
// Error history, gain products, saturated drive accumulator and duty split.
// ----------------------------------------------------------------------------
module ssip_pid
   import ssip_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  goal_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_item_type  out_item
);

   localparam int DIFF_W = ERR_W + 2;
   localparam int PROD_W = GAIN_W + 1 + DIFF_W;
   localparam int SUM_W  = TERM_W + 2;

   localparam logic signed [PROD_W:0] TERM_HI = (PROD_W+1)'(2 ** (TERM_W - 1) - 1);
   localparam logic signed [PROD_W:0] TERM_LO = -TERM_HI - (PROD_W+1)'(1);
   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(DRIVE_LIMIT);
   localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;
   localparam logic signed [ACCUM_W-1:0] ACC_HI = ACCUM_W'(DRIVE_LIMIT);
   localparam logic signed [ACCUM_W-1:0] ACC_LO = -ACC_HI;

   function automatic logic signed [TERM_W-1:0] pid_term(
      input logic [GAIN_W-1:0]        gain,
      input logic signed [DIFF_W-1:0] diff
   );
      logic signed [PROD_W-1:0] prod;
      logic [PROD_W-1:0]        mag;
      logic [PROD_W-1:0]        shr;
      logic signed [PROD_W:0]   val;
      logic signed [TERM_W-1:0] res;
      prod = $signed({1'b0, gain}) * diff;
      mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      shr  = mag >> GAIN_FRAC_BITS;
      val  = prod[PROD_W-1] ? -$signed({1'b0, shr}) : $signed({1'b0, shr});
      if (val > TERM_HI) begin
         res = {1'b0, {(TERM_W-1){1'b1}}};
      end else if (val < TERM_LO) begin
         res = {1'b1, {(TERM_W-1){1'b0}}};
      end else begin
         res = val[TERM_W-1:0];
      end
      return res;
   endfunction

   logic en_d, en_m, en_o;

   logic signed [ERR_W-1:0]   error_prev_ff, error_prev_in;
   logic signed [ERR_W-1:0]   error_prev2_ff, error_prev2_in;
   logic signed [ACCUM_W-1:0] drive_accum_ff, drive_accum_in;

   logic                      d_valid_ff, d_valid_in;
   logic signed [ERR_W-1:0]   d_e0_ff, d_e0_in;
   logic signed [DIFF_W-1:0]  d_d1_ff, d_d1_in;
   logic signed [DIFF_W-1:0]  d_d2_ff, d_d2_in;
   goal_item_type             d_item_ff;

   logic                      m_valid_ff, m_valid_in;
   logic signed [TERM_W-1:0]  m_tp_ff, m_tp_in;
   logic signed [TERM_W-1:0]  m_ti_ff, m_ti_in;
   logic signed [TERM_W-1:0]  m_td_ff, m_td_in;
   goal_item_type             m_item_ff;

   logic                      o_valid_ff, o_valid_in;
   rsp_item_type              o_item_ff, o_item_in;

   logic signed [SUM_W-1:0]   sum;
   logic signed [ACCUM_W-1:0] accum_neg;

   assign en_o     = !o_valid_ff || out_ready;
   assign en_m     = !m_valid_ff || en_o;
   assign en_d     = !d_valid_ff || en_m;
   assign in_ready = en_d;

   // error and its differences against the history
   always_comb begin
      d_valid_in     = en_d ? in_valid : d_valid_ff;
      d_e0_in        = $signed(ERR_W'(in_item.goal)) - $signed(ERR_W'(in_item.meas));
      d_d1_in        = DIFF_W'(d_e0_in) - DIFF_W'(error_prev_ff);
      d_d2_in        = DIFF_W'(d_e0_in) - (DIFF_W'(error_prev_ff) <<< 1)
                     + DIFF_W'(error_prev2_ff);
      error_prev_in  = d_e0_in;
      error_prev2_in = error_prev_ff;
   end

   always_comb begin
      m_valid_in = en_m ? d_valid_ff : m_valid_ff;
      m_tp_in    = pid_term(cfg.gain_p, d_d1_ff);
      m_ti_in    = pid_term(cfg.gain_i, DIFF_W'(d_e0_ff));
      m_td_in    = pid_term(cfg.gain_d, d_d2_ff);
   end

   always_comb begin
      o_valid_in = en_o ? m_valid_ff : o_valid_ff;
      sum = SUM_W'(drive_accum_ff) + SUM_W'(m_tp_ff) + SUM_W'(m_ti_ff) + SUM_W'(m_td_ff);
      if (sum > SUM_HI) begin
         drive_accum_in = ACC_HI;
      end else if (sum < SUM_LO) begin
         drive_accum_in = ACC_LO;
      end else begin
         drive_accum_in = sum[ACCUM_W-1:0];
      end
      accum_neg = -drive_accum_in;
      o_item_in.goal_speed     = m_item_ff.goal;
      o_item_in.measured_speed = m_item_ff.meas;
      if (drive_accum_in > $signed(ACCUM_W'(0))) begin
         o_item_in.duty_forward = drive_accum_in[DUTY_W-1:0];
         o_item_in.duty_reverse = '0;
      end else begin
         o_item_in.duty_forward = '0;
         o_item_in.duty_reverse = accum_neg[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff     <= 1'b0;
         m_valid_ff     <= 1'b0;
         o_valid_ff     <= 1'b0;
         error_prev_ff  <= '0;
         error_prev2_ff <= '0;
         drive_accum_ff <= '0;
      end else begin
         d_valid_ff <= d_valid_in;
         m_valid_ff <= m_valid_in;
         o_valid_ff <= o_valid_in;
         if (in_valid && en_d) begin
            error_prev_ff  <= error_prev_in;
            error_prev2_ff <= error_prev2_in;
         end
         if (m_valid_ff && en_o) begin
            drive_accum_ff <= drive_accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_e0_ff   <= d_e0_in;
         d_d1_ff   <= d_d1_in;
         d_d2_ff   <= d_d2_in;
         d_item_ff <= in_item;
      end
      if (en_m) begin
         m_tp_ff   <= m_tp_in;
         m_ti_ff   <= m_ti_in;
         m_td_ff   <= m_td_in;
         m_item_ff <= d_item_ff;
      end
      if (en_o) begin
         o_item_ff <= o_item_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_item  = o_item_ff;

endmodule

// ----- rtl/core/speed_schedule_incremental_pid.sv -----
// ----------------------------------------------------------------------------
// Speed schedule incremental PID
// Usage:
//   req_if carries one control tick per beat: encoder count, lane centre,
//   curve ratios, event flags and mode. rsp_if returns one beat per tick:
//   forward/reverse duty, the chosen target speed and the measured speed.
//   csr_if writes one register per beat (index, data); it is always ready.
//   Unknown indexes are dropped. Write registers only while the block is idle.
//   Pipeline: a tick passes the input register, two schedule stages,
//   error, gain products and output, in that order.
//   Throughput: one tick per cycle unless rsp_if stalls; the accumulator loop
//   closes in the last stage, so back-to-back ticks see the correct history.
//   Stall: each stage holds when its successor is full and cannot move on;
//   req_if.ready stays high while any bubble is left in the pipeline.
//   Reset (synchronous): empties the pipeline, clears the drive accumulator
//   and error history, and loads the register defaults.
// ----------------------------------------------------------------------------
module speed_schedule_incremental_pid
   import ssip_pkg::*;
#(
   parameter int GAIN_FRAC_BITS  = 4,
   parameter int RATIO_FRAC_BITS = 8
) (
   input logic          clock,
   input logic          reset,
   ssip_chan_if.sink    req_if,
   ssip_chan_if.source  rsp_if,
   ssip_chan_if.sink    csr_if
);

   cfg_type       cfg_ff, cfg_in;
   logic          req_valid_ff, req_valid_in;
   req_item_type  req_item_ff;
   logic          en_req;

   logic          goal_in_ready;
   logic          goal_valid;
   logic          pid_in_ready;
   goal_item_type goal_item;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.payload.index)
            CSR_GAIN_P:         cfg_in.gain_p         = csr_if.payload.data[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_if.payload.data[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_if.payload.data[GAIN_W-1:0];
            CSR_SPEED_LOW:      cfg_in.speed_low      = csr_if.payload.data[SPEED_W-1:0];
            CSR_SPEED_HIGH:     cfg_in.speed_high     = csr_if.payload.data[SPEED_W-1:0];
            CSR_RING_SPEEDS:    cfg_in.ring_speeds    = csr_if.payload.data;
            CSR_OBSTACLE_SPEED: cfg_in.obstacle_speed = csr_if.payload.data[SPEED_W-1:0];
            CSR_SLOW_SPEED:     cfg_in.slow_speed     = csr_if.payload.data[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   assign en_req       = !req_valid_ff || goal_in_ready;
   assign req_valid_in = en_req ? req_if.valid : req_valid_ff;
   assign req_if.ready = en_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         req_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_req) begin
         req_item_ff <= req_if.payload;
      end
   end

   ssip_goal #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_goal (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid_ff),
      .in_ready  (goal_in_ready),
      .in_item   (req_item_ff),
      .out_valid (goal_valid),
      .out_ready (pid_in_ready),
      .out_item  (goal_item)
   );

   ssip_pid #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_pid (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (goal_valid),
      .in_ready  (pid_in_ready),
      .in_item   (goal_item),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (rsp_if.payload)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result beat valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.payload.duty_forward == '0 ||
                        rsp_if.payload.duty_reverse == '0))
      else $error("forward and reverse duty both driven");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.payload.duty_forward <= DUTY_W'(DRIVE_LIMIT) &&
                        rsp_if.payload.duty_reverse <= DUTY_W'(DRIVE_LIMIT)))
      else $error("duty beyond drive limit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_if.payload)))
      else $error("result beat changed while stalled");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed schedule incremental PID testbench
// A directed table of ticks runs at the reset settings, then random ticks
// run under several register settings. Every result beat is checked against
// a fixed expected beat or a local model of the speed schedule and the PID
// drive, and the request and result channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import ssip_pkg::*;

   localparam int GAIN_FRAC_BITS  = 4;
   localparam int RATIO_FRAC_BITS = 8;
   localparam int CSR_COUNT       = 8;
   localparam int PHASE_COUNT     = 7;
   localparam int TICKS_PER_PHASE = 105;
   localparam int SETTLE_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam longint TERM_MAX    = (longint'(1) <<< (TERM_W - 1)) - 1;
   localparam longint TERM_MIN    = -(longint'(1) <<< (TERM_W - 1));

   localparam logic [4:0] F_RING  = 5'b10000;
   localparam logic [4:0] F_ENTER = 5'b01000;
   localparam logic [4:0] F_EXIT  = 5'b00100;
   localparam logic [4:0] F_OBST  = 5'b00010;
   localparam logic [4:0] F_FULL  = 5'b00001;

   typedef struct {
      req_item_type tick;
      bit           typed;
      rsp_item_type want;
   } tick_row_type;

   logic clock;
   logic reset;

   ssip_chan_if #(.payload_type(req_item_type))  req_chan ();
   ssip_chan_if #(.payload_type(rsp_item_type))  rsp_chan ();
   ssip_chan_if #(.payload_type(csr_write_type)) csr_chan ();

   speed_schedule_incremental_pid #(
      .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan),
      .csr_if (csr_chan)
   );

   cfg_type      regs;
   longint       drive_acc;
   longint       err_last;
   longint       err_last2;
   rsp_item_type duty_expected[$];
   tick_row_type tick_table[$];
   bit           tick_typed;
   rsp_item_type tick_want;
   int           errors = 0;
   int           quiet_cycles = 0;
   int           req_burst;
   int           rsp_burst = 0;
   int           rsp_hold = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint gain_term(input longint gain, input longint diff);
      longint v;
      v = gain * diff;
      if (v < 0) v = -((-v) >>> GAIN_FRAC_BITS);
      else v = v >>> GAIN_FRAC_BITS;
      if (v > TERM_MAX) v = TERM_MAX;
      if (v < TERM_MIN) v = TERM_MIN;
      return v;
   endfunction

   function automatic longint clip_curve(input longint goal, input logic [RATIO_W-1:0] ratio);
      longint lo;
      longint span;
      longint lim;
      lo   = longint'(regs.speed_low);
      span = longint'(regs.speed_high) - lo;
      if (span < 0) return goal;
      lim = (span * longint'(ratio)) >>> RATIO_FRAC_BITS;
      if (goal - lo > lim) goal = lo + lim;
      return goal;
   endfunction

   function automatic rsp_item_type compute_tick(input req_item_type t);
      rsp_item_type r;
      longint meas;
      longint goal;
      longint span;
      longint off;
      longint e0;
      longint sum;
      meas = (t.encoder_count < 0) ? 0 : longint'(t.encoder_count);
      if (t.full_speed_mode) begin
         span = longint'(regs.speed_high) - longint'(regs.speed_low);
         off  = longint'(t.center_col) - CENTER_REF;
         if (off < 0) off = -off;
         if (off > OFFSET_CAP) off = OFFSET_CAP;
         goal = (OFFSET_CAP * longint'(regs.speed_high) - span * off) / OFFSET_CAP;
         goal = clip_curve(goal, t.straight_ratio);
         goal = clip_curve(goal, t.lateral_ratio);
         if (t.ring_found)    goal = longint'(regs.ring_speeds[SPEED_W-1:0]);
         if (t.ring_entering) goal = longint'(regs.ring_speeds[2*SPEED_W-1:SPEED_W]);
         if (t.ring_exiting)  goal = longint'(regs.ring_speeds[3*SPEED_W-1:2*SPEED_W]);
         if (t.obstacle)      goal = longint'(regs.obstacle_speed);
      end else begin
         goal = longint'(regs.slow_speed);
      end
      e0  = goal - meas;
      sum = drive_acc + gain_term(longint'(regs.gain_p), e0 - err_last)
            + gain_term(longint'(regs.gain_i), e0)
            + gain_term(longint'(regs.gain_d), e0 - 2 * err_last + err_last2);
      if (sum > DRIVE_LIMIT) sum = DRIVE_LIMIT;
      if (sum < -DRIVE_LIMIT) sum = -DRIVE_LIMIT;
      drive_acc = sum;
      err_last2 = err_last;
      err_last  = e0;
      r.duty_forward   = (drive_acc > 0) ? DUTY_W'(drive_acc) : '0;
      r.duty_reverse   = (drive_acc > 0) ? '0 : DUTY_W'(-drive_acc);
      r.goal_speed     = SPEED_W'(goal);
      r.measured_speed = MEAS_W'(meas);
      return r;
   endfunction

   function automatic req_item_type mk_tick(input int enc, input int col, input int sr,
                                            input int lr, input logic [4:0] flags);
      req_item_type t;
      t.encoder_count   = enc[COUNT_W-1:0];
      t.center_col      = col[COL_W-1:0];
      t.straight_ratio  = sr[RATIO_W-1:0];
      t.lateral_ratio   = lr[RATIO_W-1:0];
      t.ring_found      = flags[4];
      t.ring_entering   = flags[3];
      t.ring_exiting    = flags[2];
      t.obstacle        = flags[1];
      t.full_speed_mode = flags[0];
      return t;
   endfunction

   function automatic req_item_type random_tick();
      int r;
      int enc;
      int col;
      int sr;
      int lr;
      logic [4:0] flags;
      r = $urandom_range(0, 99);
      if (r < 70) enc = $urandom_range(0, 600);
      else if (r < 85) enc = $urandom_range(0, 65535);
      else enc = -int'($urandom_range(1, 32768));
      col = ($urandom_range(0, 3) != 0) ? $urandom_range(15, 65) : $urandom_range(0, 255);
      sr  = ($urandom_range(0, 5) != 0) ? $urandom_range(0, 256) : $urandom_range(257, 511);
      lr  = ($urandom_range(0, 5) != 0) ? $urandom_range(0, 256) : $urandom_range(257, 511);
      flags[4] = ($urandom_range(0, 99) < 12);
      flags[3] = ($urandom_range(0, 99) < 12);
      flags[2] = ($urandom_range(0, 99) < 12);
      flags[1] = ($urandom_range(0, 99) < 12);
      flags[0] = ($urandom_range(0, 99) < 85);
      return mk_tick(enc, col, sr, lr, flags);
   endfunction

   task automatic send_tick(input req_item_type t, input bit typed, input rsp_item_type want);
      int gap;
      gap = pick_gap(req_burst);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      tick_typed       = typed;
      tick_want        = want;
      req_chan.payload = t;
      req_chan.valid   = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_chan.payload.index = idx;
      csr_chan.payload.data  = val;
      csr_chan.valid         = 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_GAIN_P:         regs.gain_p         = val[GAIN_W-1:0];
         CSR_GAIN_I:         regs.gain_i         = val[GAIN_W-1:0];
         CSR_GAIN_D:         regs.gain_d         = val[GAIN_W-1:0];
         CSR_SPEED_LOW:      regs.speed_low      = val[SPEED_W-1:0];
         CSR_SPEED_HIGH:     regs.speed_high     = val[SPEED_W-1:0];
         CSR_RING_SPEEDS:    regs.ring_speeds    = val[3*SPEED_W-1:0];
         CSR_OBSTACLE_SPEED: regs.obstacle_speed = val[SPEED_W-1:0];
         CSR_SLOW_SPEED:     regs.slow_speed     = val[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (duty_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic setup_phase(input int p);
      logic [CSR_DATA_W-1:0] vals[CSR_COUNT];
      int hi_lim;
      hi_lim = (p == 6) ? 4095 : 1023;
      vals[CSR_GAIN_P]         = CSR_DATA_W'($urandom_range(0, hi_lim));
      vals[CSR_GAIN_I]         = CSR_DATA_W'($urandom_range(0, hi_lim));
      vals[CSR_GAIN_D]         = CSR_DATA_W'($urandom_range(0, hi_lim));
      vals[CSR_SPEED_LOW]      = CSR_DATA_W'($urandom_range(0, 300));
      vals[CSR_SPEED_HIGH]     = CSR_DATA_W'($urandom_range(vals[CSR_SPEED_LOW], 511));
      vals[CSR_RING_SPEEDS]    = CSR_DATA_W'($urandom);
      vals[CSR_OBSTACLE_SPEED] = CSR_DATA_W'($urandom_range(0, 511));
      vals[CSR_SLOW_SPEED]     = CSR_DATA_W'($urandom_range(0, 511));
      case (p)
         0: foreach (vals[i]) vals[i] = '1;
         1: foreach (vals[i]) vals[i] = '0;
         2: begin
            // high speed below low speed
            vals[CSR_SPEED_LOW]  = CSR_DATA_W'($urandom_range(300, 511));
            vals[CSR_SPEED_HIGH] = CSR_DATA_W'($urandom_range(0, 250));
         end
         3: begin
            vals[CSR_GAIN_P]         = 800;
            vals[CSR_GAIN_I]         = 160;
            vals[CSR_GAIN_D]         = 48;
            vals[CSR_SPEED_LOW]      = 160;
            vals[CSR_SPEED_HIGH]     = 280;
            vals[CSR_RING_SPEEDS]    = 39406245;
            vals[CSR_OBSTACLE_SPEED] = 190;
            vals[CSR_SLOW_SPEED]     = 130;
         end
         default: ;
      endcase
      wait_idle();
      for (int i = 0; i < CSR_COUNT; i++) write_reg(CSR_INDEX_W'(i), vals[i]);
      // unmapped index, must be dropped
      write_reg(CSR_INDEX_W'(CSR_COUNT + $urandom_range(0, CSR_COUNT - 1)),
                CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // rsp side: random stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_chan.ready = 1'b1;
         rsp_hold = pick_gap(rsp_burst);
      end
   end

   // beat monitor, scoreboard and watchdog
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (req_chan.valid && req_chan.ready) begin
            want = compute_tick(req_chan.payload);
            duty_expected.push_back(tick_typed ? tick_want : want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (duty_expected.size() == 0) begin
               $error("result beat with nothing expected");
               errors++;
            end else begin
               want = duty_expected.pop_front();
               if (got.duty_forward !== want.duty_forward) begin
                  $error("duty_forward expected %0d actual %0d",
                         want.duty_forward, got.duty_forward);
                  errors++;
               end
               if (got.duty_reverse !== want.duty_reverse) begin
                  $error("duty_reverse expected %0d actual %0d",
                         want.duty_reverse, got.duty_reverse);
                  errors++;
               end
               if (got.goal_speed !== want.goal_speed) begin
                  $error("goal_speed expected %0d actual %0d",
                         want.goal_speed, got.goal_speed);
                  errors++;
               end
               if (got.measured_speed !== want.measured_speed) begin
                  $error("measured_speed expected %0d actual %0d",
                         want.measured_speed, got.measured_speed);
                  errors++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      rsp_item_type none;
      tick_row_type row;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      none             = '0;
      tick_typed       = 1'b0;
      tick_want        = '0;
      req_burst        = 0;
      regs.gain_p         = 800;
      regs.gain_i         = 160;
      regs.gain_d         = 0;
      regs.speed_low      = 160;
      regs.speed_high     = 280;
      regs.ring_speeds    = 39406245;
      regs.obstacle_speed = 190;
      regs.slow_speed     = 130;
      drive_acc = 0;
      err_last  = 0;
      err_last2 = 0;

      tick_table.push_back('{mk_tick(32767, 40, 256, 256, '0), 1'b1,
                             '{duty_forward: 0, duty_reverse: 8000,
                               goal_speed: 130, measured_speed: 32767}});
      tick_table.push_back('{mk_tick(0, 40, 256, 256, F_FULL), 1'b1,
                             '{duty_forward: 8000, duty_reverse: 0,
                               goal_speed: 280, measured_speed: 0}});
      tick_table.push_back('{mk_tick(-32768, 0, 0, 0, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(0, 255, 256, 256, F_FULL | F_RING), 1'b0, none});
      tick_table.push_back('{mk_tick(100, 45, 256, 256, F_FULL | F_ENTER), 1'b0, none});
      tick_table.push_back('{mk_tick(150, 35, 256, 256, F_FULL | F_EXIT), 1'b0, none});
      tick_table.push_back('{mk_tick(180, 40, 256, 256, F_FULL | F_OBST), 1'b0, none});
      tick_table.push_back('{mk_tick(170, 40, 256, 256, '1), 1'b0, none});
      tick_table.push_back('{mk_tick(160, 40, 256, 256, F_FULL | F_RING | F_EXIT),
                             1'b0, none});
      tick_table.push_back('{mk_tick(300, 255, 0, 0, '1 & ~F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(250, 30, 128, 256, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(250, 50, 256, 64, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(250, 41, 511, 511, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(-1, 60, 256, 256, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(1, 20, 300, 0, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(280, 40, 256, 256, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(32767, 128, 257, 1, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(-32768, 40, 256, 256, '0), 1'b0, none});
      tick_table.push_back('{mk_tick(200, 61, 255, 255, F_FULL), 1'b0, none});
      tick_table.push_back('{mk_tick(220, 39, 200, 100, F_FULL | F_ENTER | F_OBST),
                             1'b0, none});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (tick_table[i]) begin
         row = tick_table[i];
         send_tick(row.tick, row.typed, row.want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         setup_phase(p);
         repeat (TICKS_PER_PHASE) send_tick(random_tick(), 1'b0, none);
      end

      wait_idle();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/ssip_pkg.sv
rtl/core/ssip_chan_if.sv
rtl/core/ssip_goal.sv
rtl/core/ssip_pid.sv
rtl/core/speed_schedule_incremental_pid.sv
tb/testbench.sv
